/* rtl/core/ccl_pkg.sv */
// shared types, widths and codes for the card locker with auto release
// used by ccl_ctrl, ccl_dp and card_locker_with_auto_release
`timescale 1ns / 1ps

package ccl_pkg;

    localparam int ID_W            = 32;
    localparam int TICKS_W         = 20;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 1;
    localparam int KIND_W          = 2;
    localparam int ACT_W           = 2;
    localparam int SND_W           = 2;
    localparam int IN_DATA_W       = 40;
    localparam int IN_USER_W       = 3;
    localparam int OUT_DATA_W      = 8;
    localparam int DIV_STEPS       = TICKS_W;
    localparam int CNT_W           = $clog2(DIV_STEPS + 1);

    localparam int CARD_BITS_DEFAULT = 32;
    localparam int SECONDS_PER_HOUR  = 3600;

    localparam logic [CFG_W-1:0] OPEN_DELAY_RESET   = CFG_W'(0);
    localparam logic [CFG_W-1:0] TICK_SECONDS_RESET = CFG_W'(60);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DELAY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SECONDS = 1'b1;

    // event modes
    localparam logic MODE_CARD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // card kinds
    localparam logic [KIND_W-1:0] KIND_USER     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROGRAM  = 2'd1;

    // lock actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OPEN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd2;

    // sounds
    localparam logic [SND_W-1:0] SND_NONE     = 2'd0;
    localparam logic [SND_W-1:0] SND_POSITIVE = 2'd1;
    localparam logic [SND_W-1:0] SND_ERROR    = 2'd2;
    localparam logic [SND_W-1:0] SND_NEGATIVE = 2'd3;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/card_locker_with_auto_release.sv */
// top level of the card locker with auto release: config registers and module wiring
// depends on ccl_pkg, ccl_ctrl and ccl_dp
`timescale 1ns / 1ps

// channel   signals                          direction  payload
// s         s_tvalid s_tready s_tdata s_tuser  in       one card or tick event
// m         m_tvalid m_tready m_tdata          out      one result per event
// cfg       cfg_valid cfg_ready cfg_index cfg_data in   register write
//
// a user card that locks the locker runs the 20-step restoring divider for the countdown
// between its decide and commit steps; every other event goes from decide straight to commit
// one event is worked on at a time; the next is taken while a result waits in m
// a stalled m side holds the finished event in its commit step until m frees
// rst_n clears the lock state and sets open_delay_hours to 0, tick_seconds to 60

module card_locker_with_auto_release #(
    parameter int CARD_BITS = ccl_pkg::CARD_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ccl_pkg::IN_DATA_W-1:0]     s_tdata,   // card_id[31:0], door_closed, zero pad
    input  logic [ccl_pkg::IN_USER_W-1:0]     s_tuser,   // mode, card_kind[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ccl_pkg::OUT_DATA_W-1:0]    m_tdata,   // lock_action, sound, is_locked,
                                                          // timer_armed, zero pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccl_pkg::CFG_W-1:0]         cfg_data
);
    import ccl_pkg::*;

    logic [CFG_W-1:0] open_delay_reg;
    logic [CFG_W-1:0] tick_seconds_reg;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_delay_reg   <= OPEN_DELAY_RESET;
            tick_seconds_reg <= TICK_SECONDS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OPEN_DELAY:   open_delay_reg   <= cfg_data;
                CFG_TICK_SECONDS: tick_seconds_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ccl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ccl_dp #(
        .CARD_BITS (CARD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_data          (s_tdata),
        .in_user          (s_tuser),
        .open_delay_hours (open_delay_reg),
        .tick_seconds     (tick_seconds_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_data         (m_tdata)
    );

endmodule

/* rtl/core/ccl_ctrl.sv */
// controller state machine of the card locker: sequences latch, divide and commit
// depends on ccl_pkg for command and status structs
`timescale 1ns / 1ps

module ccl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ccl_pkg::dp_status_t status,
    output ccl_pkg::ctrl_cmd_t  cmd
);
    import ccl_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // wait here while the output register still holds an untaken result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ccl_dp.sv */
// datapath of the card locker: lock state, timeout divider and output register
// depends on ccl_pkg for widths, codes and command and status structs
`timescale 1ns / 1ps

module ccl_dp #(
    parameter int CARD_BITS = ccl_pkg::CARD_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ccl_pkg::ctrl_cmd_t                  cmd,
    output ccl_pkg::dp_status_t                 status,
    input  logic [ccl_pkg::IN_DATA_W-1:0]       in_data,
    input  logic [ccl_pkg::IN_USER_W-1:0]       in_user,
    input  logic [ccl_pkg::CFG_W-1:0]           open_delay_hours,
    input  logic [ccl_pkg::CFG_W-1:0]           tick_seconds,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ccl_pkg::OUT_DATA_W-1:0]      out_data
);
    import ccl_pkg::*;

    localparam int OWNER_W = (CARD_BITS < ID_W) ? CARD_BITS : ID_W;

    // latched event
    logic                mode_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [OWNER_W-1:0]  id_reg;
    logic                door_reg;

    // lock state
    logic                locked_reg;
    logic                locked_next;
    logic [OWNER_W-1:0]  owner_reg;
    logic [OWNER_W-1:0]  owner_next;
    logic [TICKS_W-1:0]  ticks_reg;
    logic [TICKS_W-1:0]  ticks_next;

    // divider
    logic [CFG_W-1:0]    rem_reg;
    logic [TICKS_W-1:0]  quot_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CFG_W-1:0]    step;
    logic [TICKS_W-1:0]  dividend;
    logic [CFG_W:0]      trial;
    logic                fits;

    // result
    logic [ACT_W-1:0]    act;
    logic [SND_W-1:0]    snd;
    logic                armed;
    logic [TICKS_W-1:0]  ticks_dec;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_user[0];
            kind_reg <= in_user[2:1];
            id_reg   <= in_data[OWNER_W-1:0];
            door_reg <= in_data[ID_W];
        end
    end

    // restoring division of hours*3600 by tick_seconds, one quotient bit a cycle
    assign step     = (tick_seconds == '0) ? CFG_W'(1) : tick_seconds;
    assign dividend = TICKS_W'(open_delay_hours) * TICKS_W'(SECONDS_PER_HOUR);
    assign trial    = {rem_reg, quot_reg[TICKS_W-1]};
    assign fits     = (trial >= {1'b0, step});

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= fits ? CFG_W'(trial - {1'b0, step}) : trial[CFG_W-1:0];
            quot_reg <= {quot_reg[TICKS_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= CNT_W'(DIV_STEPS);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign status.need_div = (mode_reg == MODE_CARD) && (kind_reg == KIND_USER)
                             && !locked_reg && door_reg;
    assign status.div_last = (cnt_reg == CNT_W'(1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign ticks_dec = ticks_reg - TICKS_W'(1);

    always_comb
    begin
        locked_next = locked_reg;
        owner_next  = owner_reg;
        ticks_next  = ticks_reg;
        act         = ACT_NONE;
        snd         = SND_NONE;
        armed       = 1'b0;
        if (mode_reg == MODE_TICK)
        begin
            // a tick with no armed countdown is ignored
            if (locked_reg && (ticks_reg != '0))
            begin
                ticks_next = ticks_dec;
                if (ticks_dec == '0)
                begin
                    locked_next = 1'b0;
                    act         = ACT_OPEN;
                    snd         = SND_POSITIVE;
                end
                else
                begin
                    armed = 1'b1;
                end
            end
        end
        else if (kind_reg == KIND_PROGRAM)
        begin
            if (locked_reg)
            begin
                locked_next = 1'b0;
                owner_next  = '0;
                ticks_next  = '0;
                act         = ACT_OPEN;
                snd         = SND_POSITIVE;
            end
            else
            begin
                snd = SND_ERROR;
            end
        end
        else if (kind_reg != KIND_USER)
        begin
            snd = SND_ERROR;
        end
        else if (!locked_reg)
        begin
            if (!door_reg)
            begin
                snd = SND_ERROR;
            end
            else
            begin
                locked_next = 1'b1;
                owner_next  = id_reg;
                ticks_next  = quot_reg;
                act         = ACT_CLOSE;
                snd         = SND_POSITIVE;
                armed       = (open_delay_hours != '0);
            end
        end
        else if (id_reg == owner_reg)
        begin
            locked_next = 1'b0;
            owner_next  = '0;
            ticks_next  = '0;
            act         = ACT_OPEN;
            snd         = SND_POSITIVE;
        end
        else
        begin
            snd = SND_NEGATIVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= 1'b0;
            owner_reg  <= '0;
            ticks_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            locked_reg <= locked_next;
            owner_reg  <= owner_next;
            ticks_reg  <= ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= {2'b00, armed, locked_next, snd, act};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* dv/card_locker_with_auto_release_tb.sv */
// self-checking testbench for card_locker_with_auto_release: directed and random card/tick
// events, random idling on both streams, a scoreboard class that predicts each result
// depends on ccl_pkg and card_locker_with_auto_release
`timescale 1ns / 1ps

module card_locker_with_auto_release_tb;

    import ccl_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SOFTWARE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_NS     = 1_500_000;
    localparam int NUM_PHASES   = 8;

    typedef struct packed {
        logic              mode;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              door;
    } locker_event_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [SND_W-1:0] snd;
        logic             locked;
        logic             armed;
    } locker_reply_t;

    class locker_scoreboard;
        logic [CFG_W-1:0]   delay_hours;
        logic [CFG_W-1:0]   tick_secs;
        logic               locked;
        logic [ID_W-1:0]    owner;
        logic [TICKS_W-1:0] ticks_left;
        locker_reply_t      pending_replies[$];
        int                 failures;

        function new();
            delay_hours = OPEN_DELAY_RESET;
            tick_secs   = TICK_SECONDS_RESET;
            locked      = 1'b0;
            owner       = '0;
            ticks_left  = '0;
            failures    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_OPEN_DELAY)
                delay_hours = val;
            else if (idx == CFG_TICK_SECONDS)
                tick_secs = val;
        endfunction

        function void note_event(locker_event_t ev);
            locker_reply_t r;
            logic [31:0]   divisor;
            r.act   = ACT_NONE;
            r.snd   = SND_NONE;
            r.armed = 1'b0;
            if (ev.mode == MODE_TICK)
            begin
                // a locked locker with no countdown ignores ticks
                if (locked && ticks_left != '0)
                begin
                    ticks_left = ticks_left - TICKS_W'(1);
                    if (ticks_left == '0)
                    begin
                        locked = 1'b0;
                        r.act  = ACT_OPEN;
                        r.snd  = SND_POSITIVE;
                    end
                    else
                        r.armed = 1'b1;
                end
            end
            else if (ev.kind == KIND_PROGRAM)
            begin
                if (locked)
                begin
                    locked     = 1'b0;
                    owner      = '0;
                    ticks_left = '0;
                    r.act      = ACT_OPEN;
                    r.snd      = SND_POSITIVE;
                end
                else
                    r.snd = SND_ERROR;
            end
            else if (ev.kind != KIND_USER)
                r.snd = SND_ERROR;
            else if (!locked)
            begin
                if (!ev.door)
                    r.snd = SND_ERROR;
                else
                begin
                    divisor    = (tick_secs == '0) ? 32'd1 : 32'(tick_secs);
                    owner      = ev.id;
                    ticks_left = TICKS_W'((32'(delay_hours) * 32'(SECONDS_PER_HOUR)) / divisor);
                    locked     = 1'b1;
                    r.act      = ACT_CLOSE;
                    r.snd      = SND_POSITIVE;
                    r.armed    = (delay_hours != '0);
                end
            end
            else if (ev.id == owner)
            begin
                owner      = '0;
                ticks_left = '0;
                locked     = 1'b0;
                r.act      = ACT_OPEN;
                r.snd      = SND_POSITIVE;
            end
            else
                r.snd = SND_NEGATIVE;
            r.locked = locked;
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [OUT_DATA_W-1:0] raw);
            locker_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("result with no event pending: m_tdata=%h", raw);
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            if (raw[1:0] != want.act)
            begin
                $error("lock_action mismatch: expected %0d, actual %0d", want.act, raw[1:0]);
                failures++;
            end
            if (raw[3:2] != want.snd)
            begin
                $error("sound mismatch: expected %0d, actual %0d", want.snd, raw[3:2]);
                failures++;
            end
            if (raw[4] != want.locked)
            begin
                $error("is_locked mismatch: expected %0d, actual %0d", want.locked, raw[4]);
                failures++;
            end
            if (raw[5] != want.armed)
            begin
                $error("timer_armed mismatch: expected %0d, actual %0d", want.armed, raw[5]);
                failures++;
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;   // card_id[31:0], door_closed, zero pad
    logic [IN_USER_W-1:0]   s_tuser   = '0;   // mode, card_kind[1:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // lock_action, sound, is_locked, timer_armed, pad
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    locker_scoreboard board = new();
    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;

    card_locker_with_auto_release dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic locker_event_t make_event(logic mode, logic [KIND_W-1:0] kind,
                                                 logic [ID_W-1:0] id, logic door);
        locker_event_t ev;
        ev.mode = mode;
        ev.kind = kind;
        ev.id   = id;
        ev.door = door;
        return ev;
    endfunction

    // a small pool of ids keeps owner matches and repeats likely
    function automatic logic [ID_W-1:0] some_card_id();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h5A5A_A5A5;
            3:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // steered by the predicted state so that lock sessions run long enough to time out
    function automatic locker_event_t next_random_event();
        locker_event_t ev;
        int            r;
        int            tick_share;
        ev = make_event(MODE_CARD, KIND_USER, some_card_id(), 1'($urandom_range(0, 1)));
        r  = $urandom_range(0, 99);
        if (board.locked)
        begin
            tick_share = (board.ticks_left != '0 && board.ticks_left <= 64) ? 90 : 30;
            if (r < tick_share)
            begin
                ev.mode = MODE_TICK;
                ev.kind = KIND_W'($urandom_range(0, 3));
            end
            else
            begin
                case ($urandom_range(0, 8))
                    0, 1:    ev.id = board.owner;
                    2, 3:    ev.kind = KIND_PROGRAM;
                    4:       ev.kind = KIND_SOFTWARE;
                    5:       ev.kind = KIND_SPARE;
                    default: ev.id = board.owner ^ (32'd1 << $urandom_range(0, 31));
                endcase
            end
        end
        else
        begin
            if (r < 15)
            begin
                ev.mode = MODE_TICK;
                ev.kind = KIND_W'($urandom_range(0, 3));
            end
            else if (r < 70)
                ev.door = 1'b1;
            else if (r < 80)
                ev.door = 1'b0;
            else if (r < 88)
                ev.kind = KIND_PROGRAM;
            else
                ev.kind = $urandom_range(0, 1) ? KIND_SOFTWARE : KIND_SPARE;
        end
        return ev;
    endfunction

    task automatic send_event(locker_event_t ev);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, ev.door, ev.id};
        s_tuser  <= {ev.kind, ev.mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_event(ev);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_W-1:0] hours, logic [CFG_W-1:0] secs);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_OPEN_DELAY;
        cfg_data  <= hours;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(CFG_OPEN_DELAY, hours);
        cfg_index <= CFG_TICK_SECONDS;
        cfg_data  <= secs;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(CFG_TICK_SECONDS, secs);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_reply(m_tdata);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30)
                stall_left = idle_cycles();
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int phase_hours[NUM_PHASES] = '{1, 0, 255, 3, 1, 2, 255, 1};
        int phase_secs[NUM_PHASES]  = '{255, 0, 1, 200, 0, 255, 255, 128};
        int phase_items[NUM_PHASES] = '{300, 80, 120, 300, 60, 250, 100, 240};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every card kind on an open and a locked locker, extreme ids,
        // ticks while open and while locked without a countdown
        send_event(make_event(MODE_TICK, KIND_USER,     '0,           1'b0));
        send_event(make_event(MODE_CARD, KIND_PROGRAM,  '0,           1'b1));
        send_event(make_event(MODE_CARD, KIND_SOFTWARE, '1,           1'b1));
        send_event(make_event(MODE_CARD, KIND_SPARE,    '1,           1'b1));
        send_event(make_event(MODE_CARD, KIND_USER,     '1,           1'b0));
        send_event(make_event(MODE_CARD, KIND_USER,     '1,           1'b1));
        send_event(make_event(MODE_TICK, KIND_SPARE,    '1,           1'b1));
        send_event(make_event(MODE_CARD, KIND_USER,     '0,           1'b1));
        send_event(make_event(MODE_CARD, KIND_SOFTWARE, '0,           1'b0));
        send_event(make_event(MODE_CARD, KIND_USER,     32'h7FFF_FFFF, 1'b1));
        send_event(make_event(MODE_CARD, KIND_USER,     '1,           1'b0));
        send_event(make_event(MODE_CARD, KIND_USER,     '0,           1'b1));
        send_event(make_event(MODE_CARD, KIND_PROGRAM,  '1,           1'b0));
        send_event(make_event(MODE_CARD, KIND_USER,     32'hA5A5_A5A5, 1'b1));
        send_event(make_event(MODE_CARD, KIND_SPARE,    32'hA5A5_A5A5, 1'b0));
        send_event(make_event(MODE_CARD, KIND_USER,     32'h5A5A_5A5A, 1'b1));
        send_event(make_event(MODE_CARD, KIND_USER,     32'hA5A5_A5A5, 1'b0));
        send_event(make_event(MODE_TICK, KIND_PROGRAM,  '1,           1'b1));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_config(CFG_W'(phase_hours[p]), CFG_W'(phase_secs[p]));
            quiet = ($urandom_range(0, 3) == 0);
            if (p == 0)
            begin
                // sender keeps offering while the result side is held off
                quiet         = 1'b1;
                long_hold_req = 1'b1;
            end
            for (int i = 0; i < phase_items[p]; i++)
                send_event(next_random_event());
        end

        quiet = 1'b0;
        drain();
        if (board.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
